>>> design/fpsb_pkg.sv
// Package for the four-point stencil blur core: register indexes, frame
// limits, reset values and the control struct passed to the result buffer.
// No dependencies.
package fpsb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int FRAME_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS     = 13;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int ROW_BITS          = 12;
  localparam int FRAME_MIN         = 3;
  localparam int FRAME_WIDTH_RST   = 1024;
  localparam int FRAME_HEIGHT_RST  = 1024;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } fpsb_reg_t;

  typedef struct packed {
    logic has0;
    logic last0;
    logic has1;
    logic end1;
  } fpsb_res_ctl_t;

endpackage

>>> design/four_point_stencil_blur_core.sv
// Top level of the four-point stencil blur: frame counters, configuration,
// line stores, window and stencil stage. Depends on fpsb_pkg,
// fpsb_line_ram and fpsb_out_buf.
//
//   channel | direction | handshake         | payload
//   in_     | slave     | tvalid/tready     | tdata: pixel
//   out_    | master    | tvalid/tready     | tdata: pixel, tlast: last of run,
//           |           |                   | tuser: frame end
//   cfg_    | write     | cfg_we            | cfg_addr, cfg_wdata
//
// One input word per cycle when not stalled; the line-store reads are issued on
// acceptance and the stencil is formed in the following cycle.
// Last-row inputs give two output words, so there the output port sets the
// pace of the input. First-row inputs give none.
// A result word is shown from the registered result buffer after its stage advances.
// Reset clears counters and control; line stores are not cleared.
// Output stalls hold the stencil stage, then the input channel.
module four_point_stencil_blur_core
  import fpsb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]     in_tdata,   // [PIXEL_BITS-1:0] in_pixel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]     out_tdata,  // [PIXEL_BITS-1:0] out_pixel
  output logic                                out_tlast,
  output logic                                out_tuser,  // [0] frame_end
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]            cfg_wdata
);

  localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = 14;
  localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

  logic [WW-1:0]                width_r;
  logic [FRAME_HEIGHT_BITS-1:0] height_r;
  logic [CW-1:0]                col_r, col_nxt;
  logic [ROW_BITS-1:0]          row_r, row_nxt;

  logic [FRAME_WIDTH_BITS-1:0]  cfg_w_raw;
  logic [FRAME_HEIGHT_BITS-1:0] cfg_h_raw;
  logic [WW-1:0]                cfg_w_clamped;
  logic [FRAME_HEIGHT_BITS-1:0] cfg_h_clamped;

  logic                  in_acc;
  logic [PIXEL_BITS-1:0] in_pix;
  logic                  c_first, c_last, r_first, r_one, r_last;
  logic [CW-1:0]         prev_rd_addr;

  logic [PIXEL_BITS-1:0] col0_r;

  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [PIXEL_BITS-1:0] s1_col0_r;
  logic [CW-1:0]         s1_col_r;
  logic                  s1_c_first_r, s1_c_last_r, s1_r_first_r, s1_r_one_r, s1_r_last_r;
  logic                  s1_adv;

  logic [PIXEL_BITS-1:0] prev_rd, older_rd;
  logic [PIXEL_BITS-1:0] win0_r, win1_r, win2_r;
  logic [PIXEL_BITS-1:0] win0_nxt, win1_nxt, win2_nxt;

  logic [PIXEL_BITS+1:0] sum;
  logic [PIXEL_BITS-1:0] stencil_pix;
  logic                  border;
  fpsb_res_ctl_t         res_ctl;
  logic                  push, push_ok;
  logic [PIXEL_BITS-1:0] buf_pix;

  // configuration
  assign cfg_w_raw = cfg_wdata[FRAME_WIDTH_BITS-1:0];
  assign cfg_h_raw = cfg_wdata[FRAME_HEIGHT_BITS-1:0];

  always_comb begin
    if (CMPW'(cfg_w_raw) < CMPW'(FRAME_MIN)) begin
      cfg_w_clamped = WW'(FRAME_MIN);
    end else if (CMPW'(cfg_w_raw) > CMPW'(MAX_WIDTH)) begin
      cfg_w_clamped = WW'(MAX_WIDTH);
    end else begin
      cfg_w_clamped = WW'(cfg_w_raw);
    end
    if (CMPW'(cfg_h_raw) < CMPW'(FRAME_MIN)) begin
      cfg_h_clamped = FRAME_HEIGHT_BITS'(FRAME_MIN);
    end else if (CMPW'(cfg_h_raw) > CMPW'(HEIGHT_LIMIT)) begin
      cfg_h_clamped = FRAME_HEIGHT_BITS'(HEIGHT_LIMIT);
    end else begin
      cfg_h_clamped = cfg_h_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= FRAME_HEIGHT_BITS'(FRAME_HEIGHT_RST);
    end else if (cfg_we) begin
      unique case (fpsb_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:  width_r  <= cfg_w_clamped;
        REG_FRAME_HEIGHT: height_r <= cfg_h_clamped;
      endcase
    end
  end

  // position of the next input word
  assign in_pix  = in_tdata[PIXEL_BITS-1:0];
  assign in_acc  = in_tvalid && in_tready;
  assign c_first = (col_r == '0);
  assign c_last  = ((WW'(col_r) + WW'(1)) == width_r);
  assign r_first = (row_r == '0);
  assign r_one   = (row_r == ROW_BITS'(1));
  assign r_last  = ((FRAME_HEIGHT_BITS'(row_r) + FRAME_HEIGHT_BITS'(1)) == height_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (c_last) begin
        col_nxt = '0;
        row_nxt = r_last ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores
  assign prev_rd_addr = c_last ? '0 : col_r + CW'(1);

  fpsb_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_r),
    .wr_data (in_pix),
    .rd_en   (in_acc),
    .rd_addr (prev_rd_addr),
    .rd_data (prev_rd)
  );

  fpsb_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_older_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (win1_nxt),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (older_rd)
  );

  // column zero of the previous row, held outside the store
  always_ff @(posedge clk) begin
    if (in_acc && c_first) begin
      col0_r <= in_pix;
    end
  end

  // stencil stage
  assign s1_adv    = s1_valid_r && (!res_ctl.has0 || push_ok);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= in_pix;
      s1_col0_r    <= col0_r;
      s1_col_r     <= col_r;
      s1_c_first_r <= c_first;
      s1_c_last_r  <= c_last;
      s1_r_first_r <= r_first;
      s1_r_one_r   <= r_one;
      s1_r_last_r  <= r_last;
    end
  end

  always_comb begin
    if (s1_c_first_r) begin
      win0_nxt = '0;
      win1_nxt = s1_col0_r;
      win2_nxt = prev_rd;
    end else begin
      win0_nxt = win1_r;
      win1_nxt = win2_r;
      win2_nxt = s1_c_last_r ? '0 : prev_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
    end else if (s1_adv) begin
      win0_r <= win0_nxt;
      win1_r <= win1_nxt;
      win2_r <= win2_nxt;
    end
  end

  assign sum = (PIXEL_BITS+2)'(win0_nxt) + (PIXEL_BITS+2)'(win2_nxt)
             + (PIXEL_BITS+2)'(older_rd) + (PIXEL_BITS+2)'(s1_pix_r);
  assign border      = s1_r_one_r || s1_c_first_r || s1_c_last_r;
  assign stencil_pix = border ? win1_nxt : sum[PIXEL_BITS+1:2];

  always_comb begin
    res_ctl.has0  = !s1_r_first_r;
    res_ctl.last0 = !s1_r_last_r;
    res_ctl.has1  = s1_r_last_r;
    res_ctl.end1  = s1_c_last_r;
  end

  assign push = s1_adv && res_ctl.has0;

  fpsb_out_buf #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ctl  (res_ctl),
    .push_pix0 (stencil_pix),
    .push_pix1 (s1_pix_r),
    .push_ok   (push_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (buf_pix),
    .out_last  (out_tlast),
    .out_end   (out_tuser)
  );

  assign out_tdata = DW'(buf_pix);

endmodule

>>> design/fpsb_line_ram.sv
// Line store: one write port and one registered read port.
// No dependencies.
module fpsb_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/fpsb_out_buf.sv
// Two-entry result buffer: takes up to two result words per input word and
// hands them to the output channel in order. Depends on fpsb_pkg.
module fpsb_out_buf
  import fpsb_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fpsb_res_ctl_t         push_ctl,
  input  logic [PIXEL_BITS-1:0] push_pix0,
  input  logic [PIXEL_BITS-1:0] push_pix1,
  output logic                  push_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_pix,
  output logic                  out_last,
  output logic                  out_end
);

  logic [1:0]            cnt_r, cnt_nxt;
  logic [PIXEL_BITS-1:0] head_pix_r, head_pix_nxt;
  logic                  head_last_r, head_last_nxt;
  logic                  head_end_r, head_end_nxt;
  logic [PIXEL_BITS-1:0] tail_pix_r, tail_pix_nxt;
  logic                  tail_end_r, tail_end_nxt;
  logic                  pop;

  assign pop     = (cnt_r != 2'd0) && out_ready;
  assign push_ok = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    cnt_nxt       = cnt_r;
    head_pix_nxt  = head_pix_r;
    head_last_nxt = head_last_r;
    head_end_nxt  = head_end_r;
    tail_pix_nxt  = tail_pix_r;
    tail_end_nxt  = tail_end_r;
    if (push) begin
      head_pix_nxt  = push_pix0;
      head_last_nxt = push_ctl.last0;
      head_end_nxt  = 1'b0;
      tail_pix_nxt  = push_pix1;
      tail_end_nxt  = push_ctl.end1;
      cnt_nxt       = push_ctl.has1 ? 2'd2 : 2'd1;
    end else if (pop) begin
      head_pix_nxt  = tail_pix_r;
      head_last_nxt = 1'b1;
      head_end_nxt  = tail_end_r;
      cnt_nxt       = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_pix_r  <= head_pix_nxt;
    head_last_r <= head_last_nxt;
    head_end_r  <= head_end_nxt;
    tail_pix_r  <= tail_pix_nxt;
    tail_end_r  <= tail_end_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_pix   = head_pix_r;
  assign out_last  = head_last_r;
  assign out_end   = head_end_r;

endmodule

>>> verif/four_point_stencil_blur_core_tb.sv
// Self-checking testbench for four_point_stencil_blur_core: streams raster
// frames through the stencil and compares every output word with a built-in
// model of the Jacobi pass. Depends on fpsb_pkg and the core RTL.
module four_point_stencil_blur_core_tb;
  import fpsb_pkg::*;

  localparam int IDX_W = $clog2(MAX_WIDTH_DEF);

  typedef struct packed {
    logic [15:0] pixel;
    logic        last;
    logic        fend;
  } pixel_word_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [15:0]              in_tdata = '0;   // [15:0] in_pixel
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [15:0]              out_tdata;       // [15:0] out_pixel
  logic                     out_tlast;
  logic                     out_tuser;       // [0] frame_end
  logic                     cfg_we = 1'b0;
  logic                     cfg_addr = REG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // blur model state
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned col_pos;
  int unsigned row_pos;
  bit [15:0]   prev_line  [MAX_WIDTH_DEF];
  bit [15:0]   older_line [MAX_WIDTH_DEF];
  bit [15:0]   win [3];

  pixel_word_t expected_pixels [$];
  int          mismatches = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          rx_holdoff = 0;

  four_point_stencil_blur_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic predict_blur(input logic [15:0] px);
    logic [17:0] sum;
    logic [15:0] centre;
    int unsigned c;
    int unsigned r;
    pixel_word_t w;
    c = col_pos;
    r = row_pos;
    if (c == 0) begin
      win[0] = '0;
      win[1] = prev_line[0];
      win[2] = prev_line[1];
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = (c + 1 < frame_w) ? prev_line[IDX_W'(c + 1)] : 16'h0000;
    end
    if (r >= 1) begin
      if (r == 1 || c == 0 || c == frame_w - 1) begin
        centre = win[1];
      end else begin
        sum = 18'(win[0]) + 18'(win[2]) + 18'(older_line[IDX_W'(c)]) + 18'(px);
        centre = sum[17:2];
      end
      w.pixel = centre;
      w.last  = (r != frame_h - 1);
      w.fend  = 1'b0;
      expected_pixels.push_back(w);
      if (r == frame_h - 1) begin
        w.pixel = px;
        w.last  = 1'b1;
        w.fend  = (c == frame_w - 1);
        expected_pixels.push_back(w);
      end
    end
    older_line[IDX_W'(c)] = win[1];
    prev_line[IDX_W'(c)]  = px;
    c++;
    if (c >= frame_w) begin
      c = 0;
      r++;
      if (r >= frame_h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // block must be idle before this is called
  task automatic write_reg(input fpsb_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = clamp_reg(32'(val[10:0]), FRAME_MIN, MAX_WIDTH_DEF);
    else frame_h = clamp_reg(32'(val), FRAME_MIN, HEIGHT_LIMIT);
    col_pos = 0;
    row_pos = 0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [15:0] px);
    if (!tx_calm) begin
      while ($urandom_range(99) < 17) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_blur(px);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: random stalls, a counted hold-off, or always ready when calm
  always @(posedge clk) begin
    if (rx_holdoff > 0) begin
      out_tready <= 1'b0;
      rx_holdoff = rx_holdoff - 1;
    end else if (rx_calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    pixel_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected word pixel=%h last=%b end=%b",
                                  out_tdata, out_tlast, out_tuser));
      end else begin
        w = expected_pixels.pop_front();
        if (out_tdata !== w.pixel)
          report_mismatch($sformatf("pixel %h, want %h", out_tdata, w.pixel));
        if (out_tlast !== w.last)
          report_mismatch($sformatf("tlast %b, want %b", out_tlast, w.last));
        if (out_tuser !== w.fend)
          report_mismatch($sformatf("frame end %b, want %b", out_tuser, w.fend));
      end
    end
  end

  // width clamped down from 2047, height clamped up from zero
  task automatic test_widest_frame();
    write_reg(REG_FRAME_WIDTH, 13'd2047);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    send_random(MAX_WIDTH_DEF + 4);
    drain_results();
  endtask

  task automatic test_directed_extremes();
    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    repeat (16) send_pixel(16'hFFFF);
    drain_results();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_pixel(16'h0000);
    drain_results();
  endtask

  task automatic test_register_clamps();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    send_random(9);
    drain_results();
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    send_random(3 * 5);
    drain_results();
    write_reg(REG_FRAME_WIDTH, 13'h1805);
    write_reg(REG_FRAME_HEIGHT, 13'd6);
    send_random(30);
    drain_results();
  endtask

  task automatic test_restart_mid_frame();
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd5);
    send_random(15);
    drain_results();
    write_reg(REG_FRAME_HEIGHT, 13'd5);
    send_random(60);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    write_reg(REG_FRAME_WIDTH, 13'd8);
    write_reg(REG_FRAME_HEIGHT, 13'd12);
    rx_holdoff = 400;
    send_random(8 * 12 * 2);
    drain_results();
  endtask

  task automatic test_steady_stream();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    write_reg(REG_FRAME_WIDTH, 13'd10);
    write_reg(REG_FRAME_HEIGHT, 13'd8);
    send_random(10 * 8);
    drain_results();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random_frames();
    int sent;
    int w;
    int h;
    int n;
    sent = 0;
    while (sent < 450) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(20, 96) : $urandom_range(3, 12);
      h = $urandom_range(3, 9);
      if ($urandom_range(1)) begin
        write_reg(REG_FRAME_WIDTH, 13'(w));
        write_reg(REG_FRAME_HEIGHT, 13'(h));
      end else begin
        write_reg(REG_FRAME_HEIGHT, 13'(h));
        write_reg(REG_FRAME_WIDTH, 13'(w));
      end
      n = w * h * $urandom_range(1, 3);
      if ($urandom_range(4) == 0) n = $urandom_range(1, n);
      if (n > 450 - sent) n = 450 - sent;
      send_random(n);
      sent += n;
      drain_results();
    end
  endtask

  initial begin
    frame_w = FRAME_WIDTH_RST;
    frame_h = FRAME_HEIGHT_RST;
    col_pos = 0;
    row_pos = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_widest_frame();
    test_directed_extremes();
    test_register_clamps();
    test_restart_mid_frame();
    test_output_backpressure();
    test_steady_stream();
    test_random_frames();
    drain_results();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/fpsb_pkg.sv
design/fpsb_line_ram.sv
design/fpsb_out_buf.sv
design/four_point_stencil_blur_core.sv
verif/four_point_stencil_blur_core_tb.sv
